FILE: hdl/tnbp_pkg.sv
// Shared types, constants and codes for the three-nearest bond placer.
package tnbp_pkg;

  localparam int COORD_W   = 32;
  localparam int KIND_W    = 8;
  localparam int BOND_W    = 31;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int ANCHOR_W  = 10;
  localparam int CFG_IDX_W = 1;
  localparam int UNIT_BITS = 30;
  localparam int MAX_ATOMS_DEF = 1024;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BOND    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIES = 1'd1;

  localparam logic [BOND_W-1:0] BOND_RESET = 31'd65536;
  localparam logic [KIND_W-1:0] KIND_RESET = 8'd0;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SCAN  = 11'b000_0000_0010,
    S_FETCH = 11'b000_0000_0100,
    S_NORM  = 11'b000_0000_1000,
    S_SQ    = 11'b000_0001_0000,
    S_SQRT  = 11'b000_0010_0000,
    S_DLOAD = 11'b000_0100_0000,
    S_DIV   = 11'b000_1000_0000,
    S_MUL   = 11'b001_0000_0000,
    S_ADD   = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [KIND_W-1:0]  kind;
  } atom_t;

endpackage

FILE: hdl/three_nearest_bond_placer_core.sv
// Top level: atom store, nearest-carbon scan and sequenced bond placement.
//
//  channel | ports                                   | dir
//  --------+-----------------------------------------+----
//  input   | in_valid/in_ready, opcode, pos, species | in
//  result  | out_valid/out_ready, new_xyz, idx, stat | out
//  config  | cfg_we, cfg_index, cfg_wdata            | in
//
// A query runs one pipelined scan over the store (one memory read per cycle),
// then up to 29 normalize shifts, 3 squares, 32 square-root steps and, per
// axis, a division and a product on one shared restoring divider and
// multiplier. Reset needs no clearing pass.
// in_ready is high only in idle; a pending result stalls only the next query
// finish, not loads.
module three_nearest_bond_placer_core #(
  parameter int MAX_ATOMS = tnbp_pkg::MAX_ATOMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tnbp_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [tnbp_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [tnbp_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [tnbp_pkg::COORD_W-1:0] in_pos_z,
  input  logic [tnbp_pkg::KIND_W-1:0]       in_species,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tnbp_pkg::COORD_W-1:0] out_new_x,
  output logic signed [tnbp_pkg::COORD_W-1:0] out_new_y,
  output logic signed [tnbp_pkg::COORD_W-1:0] out_new_z,
  output logic [tnbp_pkg::ANCHOR_W-1:0]     out_anchor_index,
  output logic [tnbp_pkg::STAT_W-1:0]       out_status,
  input  logic                              cfg_we,
  input  logic [tnbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tnbp_pkg::BOND_W-1:0]       cfg_wdata
);
  import tnbp_pkg::*;

  localparam int IDX_W = $clog2(MAX_ATOMS);
  localparam int CNT_W = $clog2(MAX_ATOMS + 1);
  localparam int DW    = COORD_W + 3;
  localparam int MW    = COORD_W + 2;
  localparam int NW    = 2 * UNIT_BITS + 1;

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] sat(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    hi = DW'(64'sh7FFF_FFFF);
    lo = -DW'(64'sh8000_0000);
    if (v > hi) return 32'h7FFF_FFFF;
    else if (v < lo) return 32'h8000_0000;
    else return v[COORD_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [BOND_W-1:0] bond_r;
  logic [KIND_W-1:0] species_r;
  logic [CNT_W-1:0]  cnt_r;

  atom_t mem [MAX_ATOMS];
  atom_t rd_q_r;
  logic  rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr;

  logic [COORD_W-1:0] q_r [3];
  logic [COORD_W-1:0] rdc [3];

  logic [CNT_W-1:0] scan_r;
  logic             issue;
  logic             p1_r, p2_r, p3_r, p4_r;
  logic [IDX_W-1:0] i1_r, i2_r, i3_r, i4_r;
  logic [COORD_W-1:0]   mag2_r [3];
  logic [2*COORD_W-1:0] sq3_r [3];
  logic [2*COORD_W+1:0] d4_r;
  logic                 scan_done;

  logic [2*COORD_W+1:0] best_d_r [3];
  logic [IDX_W-1:0]     best_i_r [3];
  logic [2:0]           best_ok_r;
  logic                 lt0, lt1, lt2;

  logic [1:0]             k_r;
  logic signed [DW-1:0]   d_r [3];
  logic signed [DW-1:0]   d_fin [3];
  logic [COORD_W-1:0]     av_r [3];
  logic [MW-1:0]          mag_r [3];
  logic [2:0]             sgn_r;
  logic [MW-1:0]          mx;

  logic [2*UNIT_BITS+1:0] acc_r;
  logic [2*UNIT_BITS-1:0] sq_w;
  logic [63:0]            sv_r, sres_r, sbit_r;
  logic [COORD_W-1:0]     n_r;
  logic [NW-1:0]          num_r;
  logic [COORD_W-1:0]     rem_r;
  logic [COORD_W:0]       rem2;
  logic                   ge;
  logic [5:0]             dcnt_r;
  logic [2*BOND_W-1:0]    prod_r;
  logic [2*BOND_W-1:0]    off_w;
  logic signed [DW-1:0]   r_w;

  logic [COORD_W-1:0]     res_r [3];
  logic [ANCHOR_W-1:0]    anchor_r;
  logic [STAT_W-1:0]      stat_r;
  logic                   out_valid_r;
  logic                   in_xfer, out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign wr_en    = in_xfer && (in_opcode == OP_LOAD) && (cnt_r != CNT_W'(MAX_ATOMS));
  assign out_free = !out_valid_r || out_ready;

  assign rdc[0] = rd_q_r.x;
  assign rdc[1] = rd_q_r.y;
  assign rdc[2] = rd_q_r.z;

  assign issue = (state_r == S_SCAN) && (scan_r != cnt_r);
  assign scan_done = (state_r == S_SCAN) && !issue && !p1_r && !p2_r && !p3_r && !p4_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_r[IDX_W-1:0];
    if (issue) begin
      rd_en = 1'b1;
    end else if (state_r == S_FETCH) begin
      case (k_r)
        2'd0: begin rd_en = 1'b1; rd_addr = best_i_r[0]; end
        2'd1: begin rd_en = 1'b1; rd_addr = best_i_r[1]; end
        2'd2: begin rd_en = 1'b1; rd_addr = best_i_r[2]; end
        default: rd_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[cnt_r[IDX_W-1:0]] <= {in_pos_x, in_pos_y, in_pos_z, in_species};
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  assign lt0 = !best_ok_r[0] || (d4_r < best_d_r[0]);
  assign lt1 = !best_ok_r[1] || (d4_r < best_d_r[1]);
  assign lt2 = !best_ok_r[2] || (d4_r < best_d_r[2]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_fin[k] = d_r[k] - DW'(signed'(rdc[k]));
    end
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    sq_w  = mag_r[k_r][UNIT_BITS-1:0] * mag_r[k_r][UNIT_BITS-1:0];
    rem2  = {rem_r, num_r[NW-1]};
    ge    = rem2 >= {1'b0, n_r};
    off_w = (prod_r + (62'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
    r_w   = sgn_r[k_r] ? DW'(signed'(av_r[k_r])) - DW'(off_w)
                       : DW'(signed'(av_r[k_r])) + DW'(off_w);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xfer && in_opcode == OP_QUERY) state_nxt = S_SCAN;
      S_SCAN:  if (scan_done) state_nxt = best_ok_r[2] ? S_FETCH : S_DONE;
      S_FETCH: if (k_r == 2'd3) state_nxt = S_NORM;
      S_NORM: begin
        if (mx == '0) state_nxt = S_DONE;
        else if (mx[MW-1:UNIT_BITS] == '0 && mx[UNIT_BITS-1]) state_nxt = S_SQ;
      end
      S_SQ:    if (k_r == 2'd2) state_nxt = S_SQRT;
      S_SQRT:  if (sbit_r == '0) state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV:   if (dcnt_r == '0) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = (k_r == 2'd2) ? S_DONE : S_DLOAD;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bond_r      <= BOND_RESET;
      species_r   <= KIND_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      p1_r <= 1'b0; p2_r <= 1'b0; p3_r <= 1'b0; p4_r <= 1'b0;
      best_ok_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOND:    bond_r    <= cfg_wdata;
          CFG_SPECIES: species_r <= cfg_wdata[KIND_W-1:0];
          default: ;
        endcase
      end
      if (wr_en) cnt_r <= cnt_r + 1'b1;
      if (in_xfer && in_opcode == OP_CLEAR) cnt_r <= '0;
      p1_r <= issue;
      p2_r <= p1_r && (rd_q_r.kind == species_r);
      p3_r <= p2_r;
      p4_r <= p3_r;
      if (in_xfer && in_opcode == OP_QUERY) best_ok_r <= '0;
      else if (p4_r) begin
        if (lt0) best_ok_r <= {best_ok_r[1], best_ok_r[0], 1'b1};
        else if (lt1) best_ok_r <= {best_ok_r[1], 1'b1, best_ok_r[0]};
        else if (lt2) best_ok_r[2] <= 1'b1;
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    i1_r <= scan_r[IDX_W-1:0];
    i2_r <= i1_r;
    i3_r <= i2_r;
    i4_r <= i3_r;
    for (int k = 0; k < 3; k++) begin
      mag2_r[k] <= absdiff(q_r[k], rdc[k]);
      sq3_r[k]  <= mag2_r[k] * mag2_r[k];
    end
    d4_r <= (2*COORD_W+2)'(sq3_r[0]) + (2*COORD_W+2)'(sq3_r[1])
          + (2*COORD_W+2)'(sq3_r[2]);
    if (issue) scan_r <= scan_r + 1'b1;
    if (p4_r) begin
      if (lt0) begin
        best_d_r[2] <= best_d_r[1]; best_i_r[2] <= best_i_r[1];
        best_d_r[1] <= best_d_r[0]; best_i_r[1] <= best_i_r[0];
        best_d_r[0] <= d4_r;        best_i_r[0] <= i4_r;
      end else if (lt1) begin
        best_d_r[2] <= best_d_r[1]; best_i_r[2] <= best_i_r[1];
        best_d_r[1] <= d4_r;        best_i_r[1] <= i4_r;
      end else if (lt2) begin
        best_d_r[2] <= d4_r;        best_i_r[2] <= i4_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        q_r[0] <= in_pos_x; q_r[1] <= in_pos_y; q_r[2] <= in_pos_z;
        scan_r <= '0;
      end
      S_SCAN: begin
        k_r <= 2'd0;
        if (scan_done && !best_ok_r[2]) begin
          stat_r <= ST_FEW; anchor_r <= '0;
          for (int k = 0; k < 3; k++) res_r[k] <= '0;
        end
      end
      S_FETCH: begin
        k_r <= k_r + 1'b1;
        for (int k = 0; k < 3; k++) begin
          case (k_r)
            2'd1: begin
              av_r[k] <= rdc[k];
              d_r[k]  <= DW'(signed'(rdc[k])) <<< 1;
            end
            2'd2: d_r[k] <= d_fin[k];
            2'd3: begin
              sgn_r[k] <= d_fin[k][DW-1];
              mag_r[k] <= d_fin[k][DW-1] ? MW'(-d_fin[k]) : MW'(d_fin[k]);
            end
            default: ;
          endcase
        end
      end
      S_NORM: begin
        k_r   <= 2'd0;
        acc_r <= '0;
        anchor_r <= ANCHOR_W'(best_i_r[0]);
        if (mx == '0) begin
          stat_r <= ST_ZERO;
          for (int k = 0; k < 3; k++) res_r[k] <= '0;
        end else if (mx[MW-1:UNIT_BITS] != '0) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
        end else if (!mx[UNIT_BITS-1]) begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
        end
      end
      S_SQ: begin
        k_r   <= k_r + 1'b1;
        acc_r <= acc_r + (2*UNIT_BITS+2)'(sq_w);
        sres_r <= '0;
        sbit_r <= 64'd1 << 62;
        if (k_r == 2'd2) sv_r <= 64'(acc_r) + 64'(sq_w);
      end
      S_SQRT: begin
        k_r <= 2'd0;
        if (sbit_r != '0) begin
          if (sv_r >= sres_r + sbit_r) begin
            sv_r   <= sv_r - (sres_r + sbit_r);
            sres_r <= (sres_r >> 1) + sbit_r;
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end else begin
          n_r <= sres_r[COORD_W-1:0];
        end
      end
      S_DLOAD: begin
        num_r  <= ({mag_r[k_r][UNIT_BITS:0], UNIT_BITS'(0)}) + NW'(n_r >> 1);
        rem_r  <= '0;
        dcnt_r <= 6'(NW - 1);
      end
      S_DIV: begin
        rem_r  <= ge ? COORD_W'(rem2 - {1'b0, n_r}) : rem2[COORD_W-1:0];
        num_r  <= {num_r[NW-2:0], ge};
        dcnt_r <= dcnt_r - 1'b1;
      end
      S_MUL: prod_r <= num_r[BOND_W-1:0] * bond_r;
      S_ADD: begin
        res_r[k_r] <= sat(r_w);
        stat_r     <= ST_OK;
        k_r        <= k_r + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_new_x        <= res_r[0];
          out_new_y        <= res_r[1];
          out_new_z        <= res_r[2];
          out_anchor_index <= anchor_r;
          out_status       <= stat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ATOMS))
    else $error("atom count past store depth");

  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    best_ok_r[1] |-> (best_ok_r[0] && best_d_r[0] <= best_d_r[1]))
    else $error("neighbor ranking out of order");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (mx[UNIT_BITS-1] && mx[MW-1:UNIT_BITS] == '0))
    else $error("direction not normalized");

endmodule
